@@ rtl/gtes_pkg.sv @@
// Shared types, constants and the month table for the GPS time sync gate.
// No dependencies; imported by every module of the block.
package gtes_pkg;

   localparam logic [31:0] EPOCH_2000_OFFSET = 32'd946684800;
   localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
   localparam logic [31:0] NO_FIX_AGE        = 32'hFFFF_FFFF;
   localparam logic [11:0] BASE_YEAR         = 12'd2000;

   localparam logic [15:0] MAX_FIX_AGE_RESET = 16'd1100;
   localparam logic [31:0] RESYNC_RESET      = 32'd3600;

   localparam logic REG_MAX_FIX_AGE = 1'b0;
   localparam logic REG_RESYNC      = 1'b1;

   localparam int IN_DATA_W  = 72;
   localparam int OUT_DATA_W = 72;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] fix_age_ms;
   } gps_fix_type;

   typedef struct packed {
      logic [15:0] max_fix_age_ms;
      logic [31:0] resync_interval_s;
   } cfg_type;

   // Days before the first of the month in a common year; out-of-range months clamp.
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd0, 4'd1: days = 9'd0;
         4'd2:       days = 9'd31;
         4'd3:       days = 9'd59;
         4'd4:       days = 9'd90;
         4'd5:       days = 9'd120;
         4'd6:       days = 9'd151;
         4'd7:       days = 9'd181;
         4'd8:       days = 9'd212;
         4'd9:       days = 9'd243;
         4'd10:      days = 9'd273;
         4'd11:      days = 9'd304;
         default:    days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

@@ rtl/gtes_csr.sv @@
// APB-style register file holding the fix age limit and the resync interval.
// Depends on gtes_pkg.
module gtes_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output gtes_pkg::cfg_type   cfg
);
   import gtes_pkg::*;

   logic [15:0] max_age_ff;
   logic [31:0] resync_ff;
   logic        wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_FIX_AGE_RESET;
         resync_ff  <= RESYNC_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_MAX_FIX_AGE) begin
            max_age_ff <= csr_pwdata[15:0];
         end else begin
            resync_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_RESYNC) begin
         csr_prdata = resync_ff;
      end else begin
         csr_prdata = {16'd0, max_age_ff};
      end
   end

   assign cfg.max_fix_age_ms    = max_age_ff;
   assign cfg.resync_interval_s = resync_ff;

endmodule

@@ rtl/gtes_unix_calc.sv @@
// Converts one GPS calendar fix into Unix seconds and judges the fix age.
// Depends on gtes_pkg.
module gtes_unix_calc (
   input  gtes_pkg::gps_fix_type fix,
   input  logic [15:0]           max_fix_age_ms,
   output logic                  fix_ok,
   output logic                  fix_young,
   output logic [31:0]           unix_seconds
);
   import gtes_pkg::*;

   logic [11:0] yr;
   logic [31:0] y32;
   logic [31:0] y_days;
   logic [31:0] leap_days;
   logic        leap_now;
   logic [31:0] days;
   logic [31:0] day_secs;
   logic [31:0] tod_secs;

   assign yr        = (fix.year >= BASE_YEAR) ? (fix.year - BASE_YEAR) : fix.year;
   assign y32       = {20'd0, yr};
   assign y_days    = (y32 << 8) + (y32 << 6) + (y32 << 5) + (y32 << 3) + (y32 << 2) + y32;
   assign leap_days = {21'd0, 11'((13'(yr) + 13'd3) >> 2)};
   assign leap_now  = (fix.month > 4'd2) && (yr[1:0] == 2'b00);

   assign days = {27'd0, fix.day} + {23'd0, days_before_month(fix.month)}
               + {31'd0, leap_now} + y_days + leap_days - 32'd1;

   assign day_secs = 32'(days * {15'd0, SECS_PER_DAY});
   assign tod_secs = 32'({27'd0, fix.hour} * 32'd3600) + 32'({26'd0, fix.minute} * 32'd60)
                   + {26'd0, fix.second};

   assign fix_ok       = (fix.fix_age_ms != NO_FIX_AGE);
   assign fix_young    = (fix.fix_age_ms < {16'd0, max_fix_age_ms});
   assign unix_seconds = fix_ok ? (EPOCH_2000_OFFSET + day_secs + tod_secs) : 32'd0;

endmodule

@@ rtl/gps_time_to_epoch_sync_gate.sv @@
// GPS fix to Unix time converter with a real-time clock write gate.
// An accepted request passes the input, conversion and result registers, which form a
// stallable three-stage pipeline, and is presented on rsp from the result register.
// Throughput: one request per cycle while rsp_tready does not stall the pipeline. The
// sync state loop closes in the last stage. Synchronous reset empties the pipeline,
// clears the sync state to zero and loads the register defaults.
module gps_time_to_epoch_sync_gate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // year, month, day, hour, minute, second, fix_age_ms, zero fill
   input  logic [gtes_pkg::IN_DATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // unix_seconds, since_last_sync, write_clock, zero fill
   output logic [gtes_pkg::OUT_DATA_W-1:0] rsp_tdata,
   // fix_ok
   output logic [0:0]                     rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import gtes_pkg::*;

   cfg_type     cfg;
   gps_fix_type req_fix;
   gps_fix_type in_fix_ff;
   logic        in_v_ff;
   logic        mid_v_ff, mid_ok_ff, mid_young_ff;
   logic [31:0] mid_unix_ff;
   logic        out_v_ff, out_ok_ff, out_write_ff;
   logic [31:0] out_unix_ff, out_diff_ff;
   logic [31:0] last_sync_ff, held_ff;
   logic        calc_ok, calc_young;
   logic [31:0] calc_unix;
   logic        ready_out, ready_mid;
   logic        out_load;
   logic [31:0] diff_in, last_sync_in, held_in;
   logic        write_in;

   gtes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_fix.year       = req_tdata[11:0];
   assign req_fix.month      = req_tdata[15:12];
   assign req_fix.day        = req_tdata[20:16];
   assign req_fix.hour       = req_tdata[25:21];
   assign req_fix.minute     = req_tdata[31:26];
   assign req_fix.second     = req_tdata[37:32];
   assign req_fix.fix_age_ms = req_tdata[69:38];

   gtes_unix_calc u_calc (
      .fix            (in_fix_ff),
      .max_fix_age_ms (cfg.max_fix_age_ms),
      .fix_ok         (calc_ok),
      .fix_young      (calc_young),
      .unix_seconds   (calc_unix)
   );

   assign ready_out  = !out_v_ff || rsp_tready;
   assign ready_mid  = !mid_v_ff || ready_out;
   assign req_tready = !in_v_ff || ready_mid;
   assign out_load   = mid_v_ff && ready_out;

   always_comb begin
      diff_in      = mid_unix_ff - last_sync_ff;
      write_in     = 1'b0;
      last_sync_in = last_sync_ff;
      held_in      = held_ff;
      if (mid_ok_ff) begin
         held_in  = diff_in;
         write_in = mid_young_ff && (diff_in > cfg.resync_interval_s);
         if (write_in) begin
            last_sync_in = mid_unix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         mid_v_ff     <= 1'b0;
         out_v_ff     <= 1'b0;
         last_sync_ff <= 32'd0;
         held_ff      <= 32'd0;
      end else begin
         if (req_tready) begin
            in_v_ff <= req_tvalid;
         end
         if (ready_mid) begin
            mid_v_ff <= in_v_ff;
         end
         if (ready_out) begin
            out_v_ff <= mid_v_ff;
         end
         if (out_load) begin
            last_sync_ff <= last_sync_in;
            held_ff      <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_fix_ff <= req_fix;
      end
      if (ready_mid && in_v_ff) begin
         mid_ok_ff    <= calc_ok;
         mid_young_ff <= calc_young;
         mid_unix_ff  <= calc_unix;
      end
      if (out_load) begin
         out_ok_ff    <= mid_ok_ff;
         out_unix_ff  <= mid_unix_ff;
         out_diff_ff  <= held_in;
         out_write_ff <= write_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, out_write_ff, out_diff_ff, out_unix_ff};
   assign rsp_tuser  = out_ok_ff;

   a_write_needs_fix : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_write_ff |-> out_ok_ff)
      else $error("clock write flagged without a valid fix");

   a_no_fix_zero_time : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_ok_ff |-> (out_unix_ff == 32'd0) && !out_write_ff)
      else $error("invalid fix carries a non-zero time or a write");

   a_sync_matches_write : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_write_ff |-> (last_sync_ff == out_unix_ff))
      else $error("stored sync time differs from the written time");

   a_sync_changes_on_write : assert property (@(posedge clock) disable iff (reset)
      !$stable(last_sync_ff) |-> $past(reset) || $past(out_load && write_in))
      else $error("sync time changed without a clock write");

endmodule
